FILE: rtl/crlf_command_framer_keepalive_assert.svh
// Assertion macros for the keep-alive command framer checker.
`ifndef CRLF_COMMAND_FRAMER_KEEPALIVE_ASSERT_SVH
`define CRLF_COMMAND_FRAMER_KEEPALIVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CFK_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfk assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CFK_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfk assertion failed");

`endif

FILE: rtl/cfk_pkg.sv
// Types, constants and command patterns for the keep-alive command framer.
package cfk_pkg;

	localparam int CMD_LEN_DEF = 9;
	localparam int KNOWN_LEN = 9;
	localparam int NUM_KNOWN = 3;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [15:0] KEEPALIVE_LIMIT_RST = 16'd600;

	localparam logic [1:0] CODE_GETDATA = 2'd0;
	localparam logic [1:0] CODE_WIFIERR = 2'd1;
	localparam logic [1:0] CODE_REGISGW = 2'd2;
	localparam logic [1:0] CODE_UNKNOWN = 2'd3;

	localparam logic [1:0] SET_LAST = 2'd2;

	// GetData, WiFierr, RegisGW, each followed by CR LF
	localparam logic [7:0] KNOWN_CMDS [NUM_KNOWN][KNOWN_LEN] = '{
		'{8'h47, 8'h65, 8'h74, 8'h44, 8'h61, 8'h74, 8'h61, 8'h0D, 8'h0A},
		'{8'h57, 8'h69, 8'h46, 8'h69, 8'h65, 8'h72, 8'h72, 8'h0D, 8'h0A},
		'{8'h52, 8'h65, 8'h67, 8'h69, 8'h73, 8'h47, 8'h57, 8'h0D, 8'h0A}
	};

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic        command_valid;
		logic [1:0]  command_code;
		logic [1:0]  data_set;
		logic        frame_error;
		logic        reset_peer;
		logic [15:0] reset_total;
	} out_t;

	// framer -> keep-alive unit
	typedef struct packed {
		logic       valid;
		logic [1:0] code;
		logic       ferr;
	} frm_ev_t;

	// keep-alive unit -> top / framer
	typedef struct packed {
		logic        peer;
		logic [1:0]  set;
		logic [15:0] total;
	} ka_res_t;

endpackage

FILE: rtl/crlf_command_framer_keepalive.sv
// Keep-alive command framer: input register, framing/keep-alive logic, result register.
// An accepted word waits in the input register, then its result goes to the result
// register and out_valid rises. Throughput: one word per cycle while results are taken;
// the two registers form a two-deep pipe, so a new word is taken while a result waits.
// Reset: arst_n clears counters, CR state, data set and reset total, and sets the
// keep-alive limit to 600; frame bytes are not cleared and need no clearing pass.
module crlf_command_framer_keepalive #(
	parameter int CMD_LEN = cfk_pkg::CMD_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cfk_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cfk_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);
	import cfk_pkg::*;

	logic     vld_s1;
	in_t      in_s1;
	logic     out_vld_q;
	out_t     out_q;

	logic     advance;
	logic     step;
	frm_ev_t  ev;
	ka_res_t  res;
	out_t     result;

	assign advance  = !out_vld_q || out_ready;
	assign step     = vld_s1 && advance;
	assign in_ready = !vld_s1 || advance;

	cfk_framer #(.CMD_LEN(CMD_LEN)) u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (in_s1),
		.peer_clr (res.peer),
		.ev       (ev)
	);

	cfk_keepalive u_keepalive (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.is_tick   (in_s1.func),
		.ev        (ev),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	always_comb begin
		result.command_valid = ev.valid;
		result.command_code  = ev.code;
		result.data_set      = res.set;
		result.frame_error   = ev.ferr;
		result.reset_peer    = res.peer;
		result.reset_total   = res.total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				vld_s1 <= 1'b1;
			end else if (step) begin
				vld_s1 <= 1'b0;
			end
			if (step) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
		if (step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/cfk_framer.sv
// Byte framer: digit/fill counters, CR tracking, frame store and command match.
module cfk_framer #(
	parameter int CMD_LEN = cfk_pkg::CMD_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  cfk_pkg::in_t   item,
	input  logic           peer_clr,
	output cfk_pkg::frm_ev_t ev
);
	import cfk_pkg::*;

	localparam int CW = $clog2(CMD_LEN + 2);
	localparam int IW = $clog2(CMD_LEN);
	localparam logic [CW-1:0] LEN_C = CW'(CMD_LEN);

	logic          after_cr_q;
	logic [CW-1:0] digit_q;
	logic [CW-1:0] fill_q;
	logic [7:0]    bytes_q [CMD_LEN];

	logic          ac_n;
	logic [CW-1:0] dig_n;
	logic [CW-1:0] fill_n;
	logic [CW-1:0] dig_inc;
	logic [CW-1:0] fill0;
	logic          ovf;
	logic          ac0;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [1:0]    known_code;

	assign dig_inc = digit_q + 1'b1;
	assign ovf     = dig_inc > LEN_C;
	assign fill0   = ovf ? '0 : fill_q;
	assign ac0     = ovf ? 1'b0 : after_cr_q;
	assign wr_idx  = fill0[IW-1:0];

	generate
		if (CMD_LEN == KNOWN_LEN) begin : g_match
			logic [NUM_KNOWN-1:0] match;

			// the incoming byte stands in for the last stored entry
			always_comb begin
				match = '1;
				for (int k = 0; k < NUM_KNOWN; k++) begin
					for (int i = 0; i < KNOWN_LEN - 1; i++) begin
						if (bytes_q[i] != KNOWN_CMDS[k][i]) begin
							match[k] = 1'b0;
						end
					end
					if (item.rx_byte != KNOWN_CMDS[k][KNOWN_LEN-1]) begin
						match[k] = 1'b0;
					end
				end
			end

			always_comb begin
				priority if (match[0]) begin
					known_code = CODE_GETDATA;
				end else if (match[1]) begin
					known_code = CODE_WIFIERR;
				end else if (match[2]) begin
					known_code = CODE_REGISGW;
				end else begin
					known_code = CODE_UNKNOWN;
				end
			end
		end else begin : g_nomatch
			assign known_code = CODE_UNKNOWN;
		end
	endgenerate

	always_comb begin
		ac_n   = after_cr_q;
		dig_n  = digit_q;
		fill_n = fill_q;
		wr_en  = 1'b0;
		ev     = '0;
		if (step && !item.func) begin
			dig_n   = ovf ? '0 : dig_inc;
			ev.ferr = ovf;
			wr_en   = fill0 < LEN_C;
			fill_n  = fill0 + 1'b1;
			if (!ac0) begin
				ac_n = (item.rx_byte == CH_CR);
			end else begin
				if (item.rx_byte == CH_LF && fill_n == LEN_C) begin
					ev.valid = 1'b1;
					ev.code  = known_code;
				end else begin
					ev.ferr = 1'b1;
				end
				fill_n = '0;
				dig_n  = '0;
				ac_n   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_cr_q <= 1'b0;
			digit_q    <= '0;
			fill_q     <= '0;
		end else begin
			after_cr_q <= ac_n;
			digit_q    <= dig_n;
			// peer reset drops the partial frame but keeps digit count and CR state
			fill_q     <= peer_clr ? '0 : fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bytes_q[wr_idx] <= item.rx_byte;
		end
	end

endmodule

FILE: rtl/cfk_keepalive.sv
// Keep-alive counter, peer reset count, data set rotation and limit register.
module cfk_keepalive (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              is_tick,
	input  cfk_pkg::frm_ev_t  ev,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output cfk_pkg::ka_res_t  res
);
	import cfk_pkg::*;

	logic [15:0] limit_q;
	logic [15:0] ka_q;
	logic [1:0]  next_set_q;
	logic [15:0] resets_q;

	logic [15:0] ka_n;
	logic [15:0] ka_inc;
	logic [1:0]  next_set_n;
	logic [15:0] resets_n;
	logic        advance;
	logic        known;
	logic        fire;

	assign known   = ev.valid && ev.code != CODE_UNKNOWN;
	assign advance = (step && is_tick) || (ev.valid && ev.code == CODE_UNKNOWN);
	assign ka_inc  = ka_q + 1'b1;
	assign fire    = advance && ka_inc >= limit_q;

	always_comb begin
		ka_n       = ka_q;
		next_set_n = next_set_q;
		resets_n   = resets_q;
		res        = '0;
		if (ev.valid && ev.code == CODE_GETDATA) begin
			res.set    = (next_set_q <= SET_LAST) ? next_set_q : 2'd0;
			next_set_n = (res.set == SET_LAST) ? 2'd0 : res.set + 1'b1;
		end
		if (known) begin
			ka_n = '0;
		end
		if (advance) begin
			ka_n = ka_inc;
		end
		if (fire) begin
			ka_n     = '0;
			resets_n = resets_q + 1'b1;
		end
		res.peer  = fire;
		res.total = resets_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= KEEPALIVE_LIMIT_RST;
			ka_q       <= '0;
			next_set_q <= '0;
			resets_q   <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			ka_q       <= ka_n;
			next_set_q <= next_set_n;
			resets_q   <= resets_n;
		end
	end

endmodule

FILE: rtl/cfk_checker.sv
// Port-level checker for the keep-alive command framer, bound to the top level.
`include "crlf_command_framer_keepalive_assert.svh"

module cfk_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input cfk_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input cfk_pkg::out_t out_data
);
	import cfk_pkg::*;

	logic cmd;
	logic ferr;
	logic peer;
	logic code_get;
	logic code_unk;
	logic set_zero;

	assign cmd      = out_data.command_valid;
	assign ferr     = out_data.frame_error;
	assign peer     = out_data.reset_peer;
	assign code_get = out_data.command_code == CODE_GETDATA;
	assign code_unk = out_data.command_code == CODE_UNKNOWN;
	assign set_zero = out_data.data_set == 2'd0;

	// a stalled input word holds
	`CFK_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))
	// a stalled result word holds
	`CFK_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// a data set is only reported with an accepted GetData, and never past the last set
	`CFK_ASSERT_IMP(a_set_getdata, out_valid && !set_zero, cmd && code_get && !(&out_data.data_set))
	// an accepted frame and a discard never share a word; code is zero without a frame
	`CFK_ASSERT_IMP(a_frame_excl, out_valid, !(cmd && ferr) && (cmd || code_get))
	// a known command clears the keep-alive count, so it can never trip a peer reset
	`CFK_ASSERT_IMP(a_peer_unknown, out_valid && peer && cmd, code_unk && !ferr)

endmodule

bind crlf_command_framer_keepalive cfk_checker u_cfk_checker (.*);
